>>> rtl/core/arlfe_pkg.sv
// shared types and constants of the aligned run-length frame encoder
package arlfe_pkg;

	localparam int CHUNK_BYTES = 16;
	localparam int CHUNK_AW    = 4;
	localparam int FILL_W      = 5;
	localparam int RUN_W       = 9;
	localparam int SRC_W       = 12;
	localparam int AMT_W       = 13;

	localparam logic [1:0] KIND_RAW    = 2'd0;
	localparam logic [1:0] KIND_OFFSET = 2'd1;
	localparam logic [1:0] KIND_RUN    = 2'd2;
	localparam logic [1:0] KIND_NULL   = 2'd3;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_RAW_RUN,
		EM_RAW_STORE,
		EM_OFFSET,
		EM_RUN,
		EM_NULL
	} emit_kind_t;

	typedef struct packed {
		logic       take_byte;
		logic       extend;
		logic       commit;
		logic       set_held;
		logic       clear_run;
		logic       chunk_reset;
		logic       frame_reset;
		logic       cnt_clear;
		logic       cnt_inc;
		emit_kind_t emit;
		logic       emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic chunk_full;
		logic uniform;
		logic run_ge2;
		logic held;
		logic match;
		logic raw_open;
		logic cnt_is_last;
		logic store_done;
		logic fill_zero;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/core/arlfe_datapath.sv
// chunk store, run and raw stretch tracking, and the result register
module arlfe_datapath #(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  arlfe_pkg::dp_cmd_t             cmd,
	output arlfe_pkg::dp_sts_t             sts,
	input  logic [7:0]                     pixel_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     result_kind,
	output logic [7:0]                     data_byte,
	output logic [arlfe_pkg::SRC_W-1:0]    entry_source,
	output logic [arlfe_pkg::AMT_W-1:0]    entry_amount,
	output logic                           last_result
);

	localparam int RUN_CAP_RAW = MAX_FRAME_BYTES / arlfe_pkg::CHUNK_BYTES;
	localparam int RUN_CAP     = (RUN_CAP_RAW > 511) ? 511 : RUN_CAP_RAW;
	localparam logic [arlfe_pkg::RUN_W-1:0] RunCap = arlfe_pkg::RUN_W'(RUN_CAP);

	logic [7:0]                    store_q [arlfe_pkg::CHUNK_BYTES];
	logic [arlfe_pkg::FILL_W-1:0]  fill_q;
	logic                          uniform_q;
	logic                          held_q;
	logic [arlfe_pkg::RUN_W-1:0]   run_q;
	logic [7:0]                    run_value_q;
	logic [arlfe_pkg::SRC_W-1:0]   raw_start_q;
	logic [arlfe_pkg::AMT_W-1:0]   raw_length_q;
	logic [arlfe_pkg::AMT_W-1:0]   raw_written_q;
	logic [arlfe_pkg::CHUNK_AW-1:0] cnt_q;
	logic                          out_valid_q;
	logic                          emitting;
	logic                          emit_raw;
	logic [arlfe_pkg::FILL_W-1:0]  cnt_next;

	assign emitting = (cmd.emit != arlfe_pkg::EM_NONE);
	assign emit_raw = (cmd.emit == arlfe_pkg::EM_RAW_RUN) || (cmd.emit == arlfe_pkg::EM_RAW_STORE);
	assign cnt_next = {1'b0, cnt_q} + arlfe_pkg::FILL_W'(1);

	assign sts.chunk_full  = (fill_q == arlfe_pkg::FILL_W'(arlfe_pkg::CHUNK_BYTES));
	assign sts.uniform     = uniform_q;
	assign sts.run_ge2     = (run_q >= arlfe_pkg::RUN_W'(2));
	assign sts.held        = held_q;
	assign sts.match       = (store_q[0] == run_value_q);
	assign sts.raw_open    = (raw_length_q != '0);
	assign sts.cnt_is_last = (cnt_q == arlfe_pkg::CHUNK_AW'(arlfe_pkg::CHUNK_BYTES - 1));
	assign sts.store_done  = (cnt_next == fill_q);
	assign sts.fill_zero   = (fill_q == '0);
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	// chunk bytes, written once per transfer
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			store_q[fill_q[arlfe_pkg::CHUNK_AW-1:0]] <= pixel_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			uniform_q     <= 1'b1;
			held_q        <= 1'b0;
			run_q         <= '0;
			run_value_q   <= '0;
			raw_start_q   <= '0;
			raw_length_q  <= '0;
			raw_written_q <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				if (fill_q != '0 && pixel_byte != store_q[0]) begin
					uniform_q <= 1'b0;
				end
				fill_q <= fill_q + arlfe_pkg::FILL_W'(1);
			end
			if (cmd.chunk_reset || cmd.frame_reset) begin
				fill_q    <= '0;
				uniform_q <= 1'b1;
			end

			if (cmd.extend) begin
				if (run_q < RunCap) begin
					run_q <= run_q + arlfe_pkg::RUN_W'(1);
				end
			end else if (cmd.commit) begin
				held_q <= 1'b0;
				run_q  <= arlfe_pkg::RUN_W'(2);
			end else if (cmd.set_held) begin
				held_q      <= 1'b1;
				run_q       <= arlfe_pkg::RUN_W'(1);
				run_value_q <= store_q[0];
			end else if (cmd.clear_run) begin
				held_q <= 1'b0;
				run_q  <= '0;
			end

			if (emit_raw) begin
				if (raw_length_q == '0) begin
					raw_start_q <= raw_written_q[arlfe_pkg::SRC_W-1:0];
				end
				raw_length_q  <= raw_length_q + arlfe_pkg::AMT_W'(1);
				raw_written_q <= raw_written_q + arlfe_pkg::AMT_W'(1);
			end else if (cmd.emit == arlfe_pkg::EM_OFFSET) begin
				raw_length_q <= '0;
			end

			if (cmd.frame_reset) begin
				run_value_q   <= '0;
				raw_start_q   <= '0;
				raw_length_q  <= '0;
				raw_written_q <= '0;
			end

			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + arlfe_pkg::CHUNK_AW'(1);
			end

			if (emitting) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, loaded only when the slot is free
	always_ff @(posedge clk) begin
		if (emitting) begin
			last_result  <= cmd.emit_last;
			data_byte    <= '0;
			entry_source <= '0;
			entry_amount <= '0;
			case (cmd.emit)
				arlfe_pkg::EM_RAW_RUN: begin
					result_kind <= arlfe_pkg::KIND_RAW;
					data_byte   <= run_value_q;
				end
				arlfe_pkg::EM_RAW_STORE: begin
					result_kind <= arlfe_pkg::KIND_RAW;
					data_byte   <= store_q[cnt_q];
				end
				arlfe_pkg::EM_OFFSET: begin
					result_kind  <= arlfe_pkg::KIND_OFFSET;
					entry_source <= raw_start_q;
					entry_amount <= raw_length_q;
				end
				arlfe_pkg::EM_RUN: begin
					result_kind  <= arlfe_pkg::KIND_RUN;
					entry_source <= {4'b0, run_value_q};
					entry_amount <= {run_q, 4'b0};
				end
				default: begin
					result_kind <= arlfe_pkg::KIND_NULL;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/arlfe_ctrl.sv
// sequencer that steps each transfer through chunk, flush and frame end handling
module arlfe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               frame_end,
	input  arlfe_pkg::dp_sts_t sts,
	output arlfe_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_FLUSH,
		S_POST,
		S_STORE,
		S_CLOSE,
		S_NULL
	} state_t;

	typedef enum logic [1:0] {
		P_HELD,
		P_STORE,
		P_TAIL
	} post_t;

	state_t state_q, state_d;
	post_t  post_q, post_d;
	logic   last_q, last_d;
	logic   tail_q, tail_d;
	logic   chunk_final;

	assign in_ready = (state_q == S_IDLE);
	// no result of a chunk step is final when the frame end follows
	assign chunk_final = !last_q && !tail_q;

	always_comb begin
		cmd         = '0;
		cmd.emit    = arlfe_pkg::EM_NONE;
		state_d     = state_q;
		post_d      = post_q;
		last_d      = last_q;
		tail_d      = tail_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					last_d        = frame_end;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.chunk_full && sts.uniform && sts.run_ge2 && sts.match) begin
					cmd.extend      = 1'b1;
					cmd.chunk_reset = 1'b1;
				end else if (sts.chunk_full && sts.uniform && sts.held && sts.match) begin
					cmd.commit      = 1'b1;
					cmd.chunk_reset = 1'b1;
				end
				if (sts.chunk_full && !(sts.uniform && (sts.run_ge2 || sts.held) && sts.match)) begin
					cmd.cnt_clear = 1'b1;
					post_d        = sts.uniform ? P_HELD : P_STORE;
					state_d       = S_FLUSH;
				end else if (sts.chunk_full && sts.uniform && !sts.run_ge2 && sts.held
						&& sts.raw_open) begin
					state_d = S_CLOSE;
				end else if (last_q) begin
					cmd.cnt_clear = 1'b1;
					post_d        = P_TAIL;
					tail_d        = 1'b1;
					state_d       = S_FLUSH;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (sts.run_ge2) begin
					if (sts.out_free) begin
						cmd.emit      = arlfe_pkg::EM_RUN;
						cmd.emit_last = (post_q == P_HELD) && chunk_final;
						cmd.clear_run = 1'b1;
						state_d       = S_POST;
					end
				end else if (sts.held) begin
					if (sts.out_free) begin
						cmd.emit    = arlfe_pkg::EM_RAW_RUN;
						cmd.cnt_inc = 1'b1;
						if (sts.cnt_is_last) begin
							cmd.emit_last = (post_q == P_HELD) && chunk_final;
							cmd.clear_run = 1'b1;
							cmd.cnt_clear = 1'b1;
							state_d       = S_POST;
						end
					end
				end else begin
					state_d = S_POST;
				end
			end
			S_POST: begin
				case (post_q)
					P_HELD: begin
						cmd.set_held    = 1'b1;
						cmd.chunk_reset = 1'b1;
						if (last_q) begin
							cmd.cnt_clear = 1'b1;
							post_d        = P_TAIL;
							tail_d        = 1'b1;
							state_d       = S_FLUSH;
						end else begin
							state_d = S_IDLE;
						end
					end
					P_STORE: begin
						state_d = S_STORE;
					end
					default: begin
						state_d = sts.fill_zero ? S_CLOSE : S_STORE;
					end
				endcase
			end
			S_STORE: begin
				if (sts.out_free) begin
					cmd.emit    = arlfe_pkg::EM_RAW_STORE;
					cmd.cnt_inc = 1'b1;
					if (sts.store_done) begin
						cmd.cnt_clear = 1'b1;
						if (post_q == P_STORE) begin
							cmd.emit_last   = chunk_final;
							cmd.chunk_reset = 1'b1;
							if (last_q) begin
								post_d  = P_TAIL;
								tail_d  = 1'b1;
								state_d = S_FLUSH;
							end else begin
								state_d = S_IDLE;
							end
						end else begin
							state_d = S_CLOSE;
						end
					end
				end
			end
			S_CLOSE: begin
				if (!sts.raw_open) begin
					state_d = S_NULL;
				end else if (sts.out_free) begin
					cmd.emit      = arlfe_pkg::EM_OFFSET;
					cmd.emit_last = chunk_final;
					if (tail_q) begin
						state_d = S_NULL;
					end else if (last_q) begin
						cmd.cnt_clear = 1'b1;
						post_d        = P_TAIL;
						tail_d        = 1'b1;
						state_d       = S_FLUSH;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_NULL: begin
				if (sts.out_free) begin
					cmd.emit        = arlfe_pkg::EM_NULL;
					cmd.emit_last   = 1'b1;
					cmd.frame_reset = 1'b1;
					tail_d          = 1'b0;
					last_d          = 1'b0;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			post_q  <= P_HELD;
			last_q  <= 1'b0;
			tail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			post_q  <= post_d;
			last_q  <= last_d;
			tail_q  <= tail_d;
		end
	end

endmodule

>>> rtl/core/aligned_run_length_frame_encoder_unit.sv
// Aligned run-length frame encoder: one pixel byte per input transfer, with frame_end on the
// last byte of a frame. Bytes are grouped into aligned 16-byte chunks; two or more adjacent
// chunks of one byte value give a value run entry, all other bytes go out raw and each raw
// stretch is closed by an offset entry; a null entry ends the frame. A byte that does not
// complete a chunk is accepted and then evaluated. A completed chunk or a frame end then steps
// through the flush, store and close states, giving up to 16 + 16 + 2 results at the frame end;
// the sequencer loads the single result register at most once per cycle and waits while it is
// not taken. The next byte is accepted while the final result still waits.
module aligned_run_length_frame_encoder_unit #(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  pixel_byte,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  result_kind,
	output logic [7:0]                  data_byte,
	output logic [arlfe_pkg::SRC_W-1:0] entry_source,
	output logic [arlfe_pkg::AMT_W-1:0] entry_amount,
	output logic                        last_result
);

	arlfe_pkg::dp_cmd_t cmd;
	arlfe_pkg::dp_sts_t sts;

	arlfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_end (frame_end),
		.sts       (sts),
		.cmd       (cmd)
	);

	arlfe_datapath #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pixel_byte   (pixel_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.data_byte    (data_byte),
		.entry_source (entry_source),
		.entry_amount (entry_amount),
		.last_result  (last_result)
	);

endmodule

>>> tb/arlfe_stream_checker.sv
// watches both channels of the run-length frame encoder, predicts its results and compares
module arlfe_stream_checker #(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [7:0]                  pixel_byte,
	input  logic                        frame_end,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  result_kind,
	input  logic [7:0]                  data_byte,
	input  logic [arlfe_pkg::SRC_W-1:0] entry_source,
	input  logic [arlfe_pkg::AMT_W-1:0] entry_amount,
	input  logic                        last_result,
	output int                          mismatches,
	output int                          results_due
);

	localparam int RUN_LIMIT = (MAX_FRAME_BYTES / arlfe_pkg::CHUNK_BYTES > 511) ?
		511 : MAX_FRAME_BYTES / arlfe_pkg::CHUNK_BYTES;

	typedef struct packed {
		logic [1:0]                  kind;
		logic [7:0]                  data;
		logic [arlfe_pkg::SRC_W-1:0] src;
		logic [arlfe_pkg::AMT_W-1:0] amt;
		logic                        last;
	} enc_result_t;

	enc_result_t expected_results[$];
	enc_result_t step_results[$];

	logic [7:0]                  chunk_bytes [arlfe_pkg::CHUNK_BYTES];
	int unsigned                 chunk_count;
	logic                        chunk_same;
	logic                        held_valid;
	logic [arlfe_pkg::RUN_W-1:0] run_len;
	logic [7:0]                  run_byte;
	logic [arlfe_pkg::SRC_W-1:0] stretch_start;
	logic [arlfe_pkg::AMT_W-1:0] stretch_len;
	logic [arlfe_pkg::AMT_W-1:0] raw_total;
	int                          error_count = 0;

	assign mismatches = error_count;

	task automatic emit(input logic [1:0] kind, input logic [7:0] data,
			input logic [arlfe_pkg::SRC_W-1:0] src, input logic [arlfe_pkg::AMT_W-1:0] amt);
		enc_result_t r;
		r.kind = kind;
		r.data = data;
		r.src  = src;
		r.amt  = amt;
		r.last = 1'b0;
		step_results = {step_results, r};
	endtask

	task automatic emit_raw(input logic [7:0] b);
		if (stretch_len == '0) stretch_start = raw_total[arlfe_pkg::SRC_W-1:0];
		stretch_len = stretch_len + 1'b1;
		raw_total   = raw_total + 1'b1;
		emit(arlfe_pkg::KIND_RAW, b, '0, '0);
	endtask

	task automatic close_stretch();
		if (stretch_len != '0) begin
			emit(arlfe_pkg::KIND_OFFSET, 8'h00, stretch_start, stretch_len);
			stretch_len = '0;
		end
	endtask

	// a committed run becomes one entry, a lone held chunk goes out raw
	task automatic flush_run();
		if (run_len >= 2) begin
			emit(arlfe_pkg::KIND_RUN, 8'h00, arlfe_pkg::SRC_W'(run_byte), {run_len, 4'h0});
		end else if (held_valid) begin
			for (int i = 0; i < arlfe_pkg::CHUNK_BYTES; i++) emit_raw(run_byte);
		end
		run_len    = '0;
		held_valid = 1'b0;
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [7:0] head;
		step_results.delete();
		if (chunk_count < arlfe_pkg::CHUNK_BYTES) begin
			if (chunk_count > 0 && b != chunk_bytes[0]) chunk_same = 1'b0;
			chunk_bytes[chunk_count] = b;
			chunk_count++;
		end
		if (chunk_count >= arlfe_pkg::CHUNK_BYTES) begin
			head = chunk_bytes[0];
			if (chunk_same) begin
				if (run_len >= 2 && head == run_byte) begin
					if (run_len < RUN_LIMIT) run_len = run_len + 1'b1;
				end else if (held_valid && head == run_byte) begin
					close_stretch();
					held_valid = 1'b0;
					run_len    = arlfe_pkg::RUN_W'(2);
				end else begin
					flush_run();
					held_valid = 1'b1;
					run_len    = arlfe_pkg::RUN_W'(1);
					run_byte   = head;
				end
			end else begin
				flush_run();
				for (int i = 0; i < arlfe_pkg::CHUNK_BYTES; i++) emit_raw(chunk_bytes[i]);
			end
			chunk_count = 0;
			chunk_same  = 1'b1;
		end
		if (fin) begin
			flush_run();
			for (int i = 0; i < chunk_count; i++) emit_raw(chunk_bytes[i]);
			close_stretch();
			emit(arlfe_pkg::KIND_NULL, 8'h00, '0, '0);
			chunk_count   = 0;
			chunk_same    = 1'b1;
			run_byte      = 8'h00;
			stretch_start = '0;
			stretch_len   = '0;
			raw_total     = '0;
		end
		if (step_results.size() > 0) begin
			step_results[step_results.size() - 1].last = 1'b1;
		end
		expected_results = {expected_results, step_results};
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		enc_result_t want;
		if (!arst_n) begin
			chunk_count   = 0;
			chunk_same    = 1'b1;
			held_valid    = 1'b0;
			run_len       = '0;
			run_byte      = 8'h00;
			stretch_start = '0;
			stretch_len   = '0;
			raw_total     = '0;
			expected_results.delete();
			results_due <= 0;
		end else begin
			if (in_valid && in_ready) encode_byte(pixel_byte, frame_end);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result_kind: expected none, got %0h", result_kind);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", 16'(want.kind), 16'(result_kind));
					check_field("data_byte", 16'(want.data), 16'(data_byte));
					check_field("entry_source", 16'(want.src), 16'(entry_source));
					check_field("entry_amount", 16'(want.amt), 16'(entry_amount));
					check_field("last_result", 16'(want.last), 16'(last_result));
				end
			end
			results_due <= expected_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// frame stimulus, handshake pacing and verdict for the run-length frame encoder
module tb_top;

	localparam int MAX_BYTES    = 4096;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_BYTES = 300;
	localparam int TAIL_CYCLES  = 64;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        in_valid   = 1'b0;
	logic                        in_ready;
	logic [7:0]                  pixel_byte = 8'h00;
	logic                        frame_end  = 1'b0;
	logic                        out_valid;
	logic                        out_ready  = 1'b0;
	logic [1:0]                  result_kind;
	logic [7:0]                  data_byte;
	logic [arlfe_pkg::SRC_W-1:0] entry_source;
	logic [arlfe_pkg::AMT_W-1:0] entry_amount;
	logic                        last_result;

	int         mismatches;
	int         results_due;
	logic       calm       = 1'b0;
	int         ready_hold = 0;
	logic [7:0] frame_bytes[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aligned_run_length_frame_encoder_unit #(
		.MAX_FRAME_BYTES(MAX_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_byte(pixel_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.entry_source(entry_source),
		.entry_amount(entry_amount),
		.last_result(last_result)
	);

	arlfe_stream_checker #(
		.MAX_FRAME_BYTES(MAX_BYTES)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_byte(pixel_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.entry_source(entry_source),
		.entry_amount(entry_amount),
		.last_result(last_result),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 20);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			ready_hold <= 0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!out_ready) begin
			out_ready  <= 1'b1;
			ready_hold <= $urandom_range(0, 12);
		end else begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready  <= 1'b0;
				ready_hold <= gap - 1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		pixel_byte <= b;
		frame_end  <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic add_fill(input logic [7:0] v, input int n);
		repeat (n) frame_bytes = {frame_bytes, v};
	endtask

	task automatic add_noise(input int n);
		repeat (n) frame_bytes = {frame_bytes, 8'($urandom)};
	endtask

	initial begin
		logic [7:0] pool [4];
		logic [7:0] last_val;
		int         random_sent;
		int         chunks;
		int         pick;
		int         base;
		int         tail;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte frames at both extremes, a lone uniform chunk before a partial one
		frame_bytes = {8'h00};
		send_frame();
		frame_bytes = {8'hFF};
		send_frame();
		frame_bytes.delete();
		add_fill(8'hAA, 17);
		send_frame();
		frame_bytes = {8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00};
		send_frame();

		random_sent = 0;
		while (random_sent < RANDOM_BYTES) begin
			calm <= ($urandom_range(0, 5) == 0);
			frame_bytes.delete();
			pool[0]  = 8'h00;
			pool[1]  = 8'hFF;
			pool[2]  = 8'($urandom);
			pool[3]  = 8'($urandom);
			last_val = pool[$urandom_range(0, 3)];
			if ($urandom_range(0, 4) == 0) begin
				add_noise($urandom_range(1, 40));
			end else begin
				chunks = $urandom_range(0, 6);
				for (int c = 0; c < chunks; c++) begin
					// sticky value so that adjacent uniform chunks often match
					if ($urandom_range(0, 2) == 0) last_val = pool[$urandom_range(0, 3)];
					pick = $urandom_range(0, 7);
					base = frame_bytes.size();
					if (pick < 4) begin
						add_fill(last_val, arlfe_pkg::CHUNK_BYTES);
					end else if (pick < 6) begin
						add_noise(arlfe_pkg::CHUNK_BYTES);
					end else begin
						add_fill(last_val, arlfe_pkg::CHUNK_BYTES);
						base = base + $urandom_range(0, arlfe_pkg::CHUNK_BYTES - 1);
						frame_bytes[base] = frame_bytes[base] ^ 8'($urandom_range(1, 255));
					end
				end
				tail = $urandom_range((chunks == 0) ? 1 : 0, arlfe_pkg::CHUNK_BYTES - 1);
				if ($urandom_range(0, 1) == 0) add_fill(last_val, tail);
				else add_noise(tail);
			end
			random_sent += frame_bytes.size();
			send_frame();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_due == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
